/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/i2cm_pkg.sv */
package i2cm_pkg;

  // Transaction opcodes
  localparam logic [2:0] OP_WR_CTL   = 3'd0;
  localparam logic [2:0] OP_WR_DATA  = 3'd1;
  localparam logic [2:0] OP_RD_CTL   = 3'd2;
  localparam logic [2:0] OP_RD_STAT  = 3'd3;
  localparam logic [2:0] OP_RD_DATA  = 3'd4;
  localparam logic [2:0] OP_COMPLETE = 3'd5;

  // Control register bit positions
  localparam int unsigned CTL_AAK  = 2;
  localparam int unsigned CTL_IFLG = 3;
  localparam int unsigned CTL_STP  = 4;
  localparam int unsigned CTL_STA  = 5;
  localparam int unsigned CTL_ENAB = 6;

  // Master status codes
  localparam logic [7:0] ST_START  = 8'h08;
  localparam logic [7:0] ST_RSTART = 8'h10;
  localparam logic [7:0] ST_AW_ACK = 8'h18;
  localparam logic [7:0] ST_AW_NAK = 8'h20;
  localparam logic [7:0] ST_DW_ACK = 8'h28;
  localparam logic [7:0] ST_DW_NAK = 8'h30;
  localparam logic [7:0] ST_ARB    = 8'h38;
  localparam logic [7:0] ST_AR_ACK = 8'h40;
  localparam logic [7:0] ST_AR_NAK = 8'h48;
  localparam logic [7:0] ST_RX_ACK = 8'h50;
  localparam logic [7:0] ST_RX_NAK = 8'h58;
  localparam logic [7:0] ST_IDLE   = 8'hF8;

  // Pending bus phase
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_RESTART = 3'd2;
  localparam logic [2:0] PH_ADDR    = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;
  localparam logic [2:0] PH_RXACK   = 3'd5;
  localparam logic [2:0] PH_RXNAK   = 3'd6;

  // Launched bus action
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_RESTART = 3'd2;
  localparam logic [2:0] ACT_SEND    = 3'd3;
  localparam logic [2:0] ACT_RXACK   = 3'd4;
  localparam logic [2:0] ACT_RXNAK   = 3'd5;
  localparam logic [2:0] ACT_STOP    = 3'd6;

endpackage

/* rtl/core/i2c_master_status_core.sv */
// Master-mode two-wire bus register core. Each input transaction is a register
// access (control write, data write, control/status/data read) or a bus
// completion event, and each yields exactly one result transaction carrying
// the read value (zero for non-reads), the bus action launched (none, start,
// restart, send byte, receive with ack/nak, stop) and the interrupt flag as it
// stands afterwards. Throughput is one transaction per clock while out_stall
// is low. A transaction accepted into the input register passes the single
// decision stage that updates control, data, status, pending phase and bus
// ownership, and is offered from the result register. A stop written
// with ENAB set takes effect at once and returns the status to 0xF8; a
// completion with nothing pending is ignored. After reset the status reads
// 0xF8 and the control and data registers read zero. Both channels use
// valid/stall: a transaction moves on a rising edge with valid high and stall
// low, and out_stall backs up into in_stall in the same cycle.
module i2c_master_status_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_wdata,
  input  logic       in_partner_ack,
  input  logic       in_arb_lost,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_rdata,
  output logic [2:0] out_bus_action,
  output logic       out_irq_flag
);

  // Input register stage
  logic       s1_valid_r;
  logic [2:0] s1_op_r;
  logic [7:0] s1_wdata_r;
  logic       s1_ack_r;
  logic       s1_lost_r;
  logic [7:0] s1_rx_r;

  // Architectural state
  logic [7:0] ctl_r, ctl_nxt;
  logic [7:0] data_r, data_nxt;
  logic [7:0] status_r, status_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic       owned_r, owned_nxt;
  logic       rd_dir_r, rd_dir_nxt;

  // Result register
  logic       out_valid_r;
  logic [7:0] out_rdata_r, rdata_nxt;
  logic [2:0] out_act_r, act_nxt;
  logic       out_irq_r;

  logic advance;
  logic in_take;

  // The decision stage empties whenever the result register is free or is
  // being drained this cycle.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Hold the payload while stalled; load on acceptance only.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= in_op;
      s1_wdata_r <= in_wdata;
      s1_ack_r   <= in_partner_ack;
      s1_lost_r  <= in_arb_lost;
      s1_rx_r    <= in_rx_byte;
    end
  end

  // Decision logic: one transaction's effect on the register file.
  always_comb begin
    logic       flag_before;
    logic       keep_flag;
    logic [7:0] st;

    flag_before = ctl_r[i2cm_pkg::CTL_IFLG];
    keep_flag   = s1_wdata_r[i2cm_pkg::CTL_IFLG] & ctl_r[i2cm_pkg::CTL_IFLG];
    st          = status_r;

    ctl_nxt    = ctl_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    phase_nxt  = phase_r;
    owned_nxt  = owned_r;
    rd_dir_nxt = rd_dir_r;
    rdata_nxt  = 8'h00;
    act_nxt    = i2cm_pkg::ACT_NONE;

    unique case (s1_op_r)
      i2cm_pkg::OP_WR_CTL: begin
        // STA and STP act at once and are never stored; IFLG written as one leaves the
        // flag as it was unless a start or stop is launched.
        ctl_nxt = s1_wdata_r;
        ctl_nxt[i2cm_pkg::CTL_STA]  = 1'b0;
        ctl_nxt[i2cm_pkg::CTL_STP]  = 1'b0;
        ctl_nxt[i2cm_pkg::CTL_IFLG] = keep_flag;
        priority if (!s1_wdata_r[i2cm_pkg::CTL_ENAB]) begin
          act_nxt = i2cm_pkg::ACT_NONE;
        end else if (s1_wdata_r[i2cm_pkg::CTL_STP]) begin
          // Stop wins over start and over a pending action once ENAB is set.
          phase_nxt = i2cm_pkg::PH_IDLE;
          ctl_nxt[i2cm_pkg::CTL_IFLG] = 1'b0;
          owned_nxt  = 1'b0;
          status_nxt = i2cm_pkg::ST_IDLE;
          act_nxt    = i2cm_pkg::ACT_STOP;
        end else if (phase_r != i2cm_pkg::PH_IDLE) begin
          act_nxt = i2cm_pkg::ACT_NONE;
        end else if (s1_wdata_r[i2cm_pkg::CTL_STA]) begin
          ctl_nxt[i2cm_pkg::CTL_IFLG] = 1'b0;
          if (owned_r) begin
            phase_nxt = i2cm_pkg::PH_RESTART;
            act_nxt   = i2cm_pkg::ACT_RESTART;
          end else begin
            phase_nxt = i2cm_pkg::PH_START;
            act_nxt   = i2cm_pkg::ACT_START;
          end
        end else if (flag_before && !s1_wdata_r[i2cm_pkg::CTL_IFLG] && owned_r) begin
          // Continue from the current status.
          unique case (status_r)
            i2cm_pkg::ST_START, i2cm_pkg::ST_RSTART: begin
              rd_dir_nxt = data_r[0];
              phase_nxt  = i2cm_pkg::PH_ADDR;
              act_nxt    = i2cm_pkg::ACT_SEND;
            end
            i2cm_pkg::ST_AW_ACK, i2cm_pkg::ST_DW_ACK: begin
              phase_nxt = i2cm_pkg::PH_DATA;
              act_nxt   = i2cm_pkg::ACT_SEND;
            end
            i2cm_pkg::ST_AR_ACK, i2cm_pkg::ST_RX_ACK: begin
              if (s1_wdata_r[i2cm_pkg::CTL_AAK]) begin
                phase_nxt = i2cm_pkg::PH_RXACK;
                act_nxt   = i2cm_pkg::ACT_RXACK;
              end else begin
                phase_nxt = i2cm_pkg::PH_RXNAK;
                act_nxt   = i2cm_pkg::ACT_RXNAK;
              end
            end
            default: act_nxt = i2cm_pkg::ACT_NONE;
          endcase
        end else begin
          act_nxt = i2cm_pkg::ACT_NONE;
        end
      end
      i2cm_pkg::OP_WR_DATA: data_nxt = s1_wdata_r;
      i2cm_pkg::OP_RD_CTL:  rdata_nxt = ctl_r;
      i2cm_pkg::OP_RD_STAT: rdata_nxt = status_r;
      i2cm_pkg::OP_RD_DATA: rdata_nxt = data_r;
      i2cm_pkg::OP_COMPLETE: begin
        if (phase_r != i2cm_pkg::PH_IDLE) begin
          if (s1_lost_r) begin
            st        = i2cm_pkg::ST_ARB;
            owned_nxt = 1'b0;
          end else begin
            unique case (phase_r)
              i2cm_pkg::PH_START: begin
                st        = i2cm_pkg::ST_START;
                owned_nxt = 1'b1;
              end
              i2cm_pkg::PH_RESTART: begin
                st        = i2cm_pkg::ST_RSTART;
                owned_nxt = 1'b1;
              end
              i2cm_pkg::PH_ADDR: begin
                if (rd_dir_r) begin
                  st = s1_ack_r ? i2cm_pkg::ST_AR_ACK : i2cm_pkg::ST_AR_NAK;
                end else begin
                  st = s1_ack_r ? i2cm_pkg::ST_AW_ACK : i2cm_pkg::ST_AW_NAK;
                end
              end
              i2cm_pkg::PH_DATA: begin
                st = s1_ack_r ? i2cm_pkg::ST_DW_ACK : i2cm_pkg::ST_DW_NAK;
              end
              i2cm_pkg::PH_RXACK: begin
                data_nxt = s1_rx_r;
                st       = i2cm_pkg::ST_RX_ACK;
              end
              default: begin
                // Receive with nak; partner acknowledge is ignored.
                data_nxt = s1_rx_r;
                st       = i2cm_pkg::ST_RX_NAK;
              end
            endcase
          end
          status_nxt = st;
          phase_nxt  = i2cm_pkg::PH_IDLE;
          ctl_nxt[i2cm_pkg::CTL_IFLG] = 1'b1;
        end
      end
      default: act_nxt = i2cm_pkg::ACT_NONE;
    endcase
  end

  // Commit state only when the transaction moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r    <= 8'h00;
      data_r   <= 8'h00;
      status_r <= i2cm_pkg::ST_IDLE;
      phase_r  <= i2cm_pkg::PH_IDLE;
      owned_r  <= 1'b0;
      rd_dir_r <= 1'b0;
    end else if (advance) begin
      ctl_r    <= ctl_nxt;
      data_r   <= data_nxt;
      status_r <= status_nxt;
      phase_r  <= phase_nxt;
      owned_r  <= owned_nxt;
      rd_dir_r <= rd_dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rdata_r <= rdata_nxt;
      out_act_r   <= act_nxt;
      out_irq_r   <= ctl_nxt[i2cm_pkg::CTL_IFLG];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rdata      = out_rdata_r;
  assign out_bus_action = out_act_r;
  assign out_irq_flag   = out_irq_r;

endmodule

/* rtl/core/i2cm_checker.sv */
`include "assert_macros.svh"

module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_rdata,
  input logic [2:0] out_bus_action,
  input logic       out_irq_flag
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_rdata) && $stable(out_bus_action) && $stable(out_irq_flag), "stalled result changed")
  `ASSERT_IMPLY(a_act_range, clk, rst_n, out_valid, out_bus_action <= i2cm_pkg::ACT_STOP, "bus action code out of range")
  `ASSERT_IMPLY(a_launch_clears_irq, clk, rst_n, out_valid && (out_bus_action == i2cm_pkg::ACT_STOP || out_bus_action == i2cm_pkg::ACT_START || out_bus_action == i2cm_pkg::ACT_RESTART), !out_irq_flag, "start, restart or stop left the flag set")
  `ASSERT_IMPLY(a_read_no_launch, clk, rst_n, out_valid && out_bus_action != i2cm_pkg::ACT_NONE, out_rdata == 8'h00, "launching transaction returned read data")
  `ASSERT_IMPLY(a_stall_backpressure, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a stalled result")

endmodule

bind i2c_master_status_core i2cm_checker u_i2cm_checker (.*);
